>>> design/umidi_pkg.sv
package umidi_pkg;

    // ring geometry
    localparam int RING_DEPTH = 1024;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    // input opcodes
    localparam logic [1:0] OP_PACKET  = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_DRAIN   = 2'd2;

    // bytes pushed per code index number
    localparam logic [1:0] CIN_LEN [16] = '{
        2'd0, 2'd0, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd1
    };

    // private editor sysex message
    localparam int         MSG_LEN = 7;
    localparam logic [7:0] EDITOR_MSG [MSG_LEN] = '{
        8'hf0, 8'h7d, 8'h4d, 8'h50, 8'h4b, 8'h01, 8'hf7
    };

    // request from the sequencer to the ring
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       pop;
    } ring_req_t;

    // ring status back to the sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    // pointer step with wrap at any depth
    function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            return '0;
        end else begin
            return p + 1'b1;
        end
    endfunction

endpackage

>>> design/umidi_ram.sv
module umidi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/umidi_ring.sv
module umidi_ring
    import umidi_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  ring_req_t  req,
    output ring_stat_t stat,
    output logic [7:0] pop_data
);

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             do_write;

    // status from the pointers
    assign stat.empty = (rd_ptr_reg == wr_ptr_reg);
    assign stat.full  = (ptr_step(wr_ptr_reg) == rd_ptr_reg);

    // a push into a full ring is dropped
    assign do_write = req.push && !stat.full;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_write) begin
            wr_ptr_next = ptr_step(wr_ptr_reg);
        end
        if (req.pop && !stat.empty) begin
            rd_ptr_next = ptr_step(rd_ptr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // byte storage
    umidi_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (wr_ptr_reg),
        .wdata (req.push_byte),
        .re    (req.pop),
        .raddr (rd_ptr_reg),
        .rdata (pop_data)
    );

`ifndef SYNTHESIS
    a_drop_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        req.push && stat.full |=> $stable(wr_ptr_reg))
        else $error("write pointer moved on a push into a full ring");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        req.pop |-> !stat.empty)
        else $error("read issued on an empty ring");
`endif

endmodule

>>> design/usb_midi_packet_to_serial_fifo.sv
// a drain word's byte moves from DRAIN through the ring ram read register and
//   WAIT into the output register on m_tdata; DRAIN holds while the output word
//   is held and ends the drain on an empty ring; a packet word pushes its n data
//   bytes (n = 0..3) and a command word seven bytes, the ram writing one a cycle
// a finished byte waits in the output register while the next word is accepted
// reset: both ring pointers go to zero, the ring ram is not cleared
module usb_midi_packet_to_serial_fifo
    import umidi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cin_header, data_byte_one, data_byte_two, data_byte_three
    input  logic [31:0] s_tdata,
    // opcode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_byte
    output logic [7:0]  m_tdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PUSH  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       cmd_reg, cmd_next;
    logic [7:0] pkt_reg [3];
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;

    ring_req_t  req;
    ring_stat_t stat;
    logic [7:0] pop_data;
    logic       s_fire;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        req.push       = 1'b0;
        req.push_byte  = cmd_reg ? EDITOR_MSG[idx_reg] : pkt_reg[idx_reg[1:0]];
        req.pop        = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    idx_next = '0;
                    unique case (s_tuser)
                        OP_PACKET: begin
                            cmd_next = 1'b0;
                            cnt_next = {1'b0, CIN_LEN[s_tdata[3:0]]};
                            if (CIN_LEN[s_tdata[3:0]] != 2'd0) begin
                                state_next = ST_PUSH;
                            end
                        end
                        OP_COMMAND: begin
                            cmd_next   = 1'b1;
                            cnt_next   = 3'(MSG_LEN);
                            state_next = ST_PUSH;
                        end
                        OP_DRAIN: begin
                            state_next = ST_DRAIN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PUSH: begin
                req.push = 1'b1;
                idx_next = idx_reg + 3'd1;
                if ((idx_reg + 3'd1) == cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (stat.empty) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    req.pop    = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                out_valid_next = 1'b1;
                out_data_next  = pop_data;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
        if (s_fire) begin
            pkt_reg[0] <= s_tdata[15:8];
            pkt_reg[1] <= s_tdata[23:16];
            pkt_reg[2] <= s_tdata[31:24];
        end
    end

    umidi_ring u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .stat     (stat),
        .pop_data (pop_data)
    );

`ifndef SYNTHESIS
    a_load_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WAIT))
        else $error("output word loaded without a ring read");

    a_wait_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WAIT |-> !out_valid_reg)
        else $error("ring read returned while the output register is full");
`endif

endmodule

>>> verif/usb_midi_packet_to_serial_fifo_tb.sv
`timescale 1ns / 1ps

module usb_midi_packet_to_serial_fifo_tb;
    import umidi_pkg::*;

    // opcode the block does not use
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // data bytes queued per code index number
    localparam int PKT_LEN_BY_CODE [16] = '{
        0, 0, 2, 3, 3, 1, 2, 3, 3, 3, 3, 3, 2, 2, 3, 1
    };

    // private editor sysex bytes in send order
    localparam logic [7:0] EDITOR_BYTES [7] = '{
        8'hf0, 8'h7d, 8'h4d, 8'h50, 8'h4b, 8'h01, 8'hf7
    };

    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 200000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // cin_header, data_byte_one, data_byte_two, data_byte_three
    logic [31:0] s_tdata  = '0;
    // opcode
    logic [1:0]  s_tuser  = OP_PACKET;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // tx_byte
    logic [7:0]  m_tdata;

    // idle and stall odds in percent
    int gap_pct   = 0;
    int stall_pct = 0;

    // handshake seen at the last falling edge
    logic took_word = 1'b0;

    // shadow copy of the byte ring
    logic [7:0]  ring_copy [RING_DEPTH];
    int unsigned wr_slot = 0;
    int unsigned rd_slot = 0;

    logic [7:0] tx_expected_q [$];

    int err_count     = 0;
    int words_seen    = 0;
    int bytes_checked = 0;
    int bytes_dropped = 0;
    int empty_drains  = 0;

    usb_midi_packet_to_serial_fifo u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5000000;
        $display("[usb_midi_packet_to_serial_fifo] ERROR");
        $finish;
    end

    function automatic int unsigned step_slot(input int unsigned p);
        return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int fill_level();
        return (wr_slot + RING_DEPTH - rd_slot) % RING_DEPTH;
    endfunction

    task automatic flag_mismatch(input string what);
        if (err_count < 20) begin
            $display("mismatch at %0t: %s", $time, what);
        end
        err_count++;
    endtask

    // byte into the shadow ring, dropped when full
    task automatic enqueue_byte(input logic [7:0] b);
        if (step_slot(wr_slot) == rd_slot) begin
            bytes_dropped++;
        end else begin
            ring_copy[wr_slot] = b;
            wr_slot = step_slot(wr_slot);
        end
    endtask

    // predict the effect of one accepted word
    task automatic apply_word(input logic [1:0] op, input logic [31:0] d);
        logic [7:0] pkt [3];
        pkt[0] = d[15:8];
        pkt[1] = d[23:16];
        pkt[2] = d[31:24];
        words_seen++;
        case (op)
            OP_PACKET: begin
                for (int k = 0; k < PKT_LEN_BY_CODE[d[3:0]]; k++) enqueue_byte(pkt[k]);
            end
            OP_COMMAND: begin
                for (int k = 0; k < 7; k++) enqueue_byte(EDITOR_BYTES[k]);
            end
            OP_DRAIN: begin
                if (rd_slot == wr_slot) begin
                    empty_drains++;
                end else begin
                    tx_expected_q.push_back(ring_copy[rd_slot]);
                    rd_slot = step_slot(rd_slot);
                end
            end
            OP_UNUSED: ;
            default: ;
        endcase
    endtask

    task automatic check_byte(input logic [7:0] got);
        logic [7:0] want;
        if (tx_expected_q.size() == 0) begin
            flag_mismatch($sformatf("tx_byte %02h with nothing queued", got));
        end else begin
            want = tx_expected_q.pop_front();
            bytes_checked++;
            if (got !== want) begin
                flag_mismatch($sformatf("tx_byte %02h, want %02h", got, want));
            end
        end
    endtask

    // sample both channels mid-cycle; the transfer lands on the next rising edge
    always @(negedge aclk) begin
        took_word = aresetn && s_tvalid && s_tready;
        if (took_word) apply_word(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) check_byte(m_tdata);
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // present one word and hold it until it is taken
    task automatic send_word(input logic [1:0] op, input logic [7:0] hdr,
                             input logic [7:0] b1, input logic [7:0] b2,
                             input logic [7:0] b3);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b3, b2, b1, hdr};
        @(posedge aclk);
        while (!took_word) @(posedge aclk);
    endtask

    task automatic send_drain();
        send_word(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // stop input, wait for every queued byte, then let the block go quiet
    task automatic settle_out();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (tx_expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // empty the ring, then one drain on an empty ring
    task automatic drain_ring();
        while (fill_level() != 0) send_drain();
        send_drain();
    endtask

    // every code index, extreme bytes, command, unused opcode, empty drain
    task automatic test_directed();
        logic [7:0] hdr;
        send_drain();
        send_word(OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
        for (int i = 0; i < 16; i++) begin
            hdr = {(i % 2 == 1) ? 4'hf : 4'h0, 4'(i)};
            send_word(OP_PACKET, hdr, (i % 2 == 0) ? 8'h00 : 8'hff, 8'h80 | 8'(i),
                      (i % 2 == 0) ? 8'hff : 8'h01);
        end
        send_word(OP_COMMAND, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (6) send_drain();
        drain_ring();
        settle_out();
    endtask

    // fill the ring, overflow part way through a packet and a command
    task automatic test_ring_full();
        while (RING_DEPTH - 1 - fill_level() >= 7) begin
            send_word(OP_COMMAND, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        while (RING_DEPTH - 1 - fill_level() > 1) begin
            send_word(OP_PACKET, 8'h15, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        send_word(OP_PACKET, 8'h03, 8'h90, 8'h3c, 8'h7f);
        send_word(OP_COMMAND, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (3) send_drain();
        send_word(OP_COMMAND, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_PACKET, 8'h04, 8'hf0, 8'h01, 8'h02);
        repeat (3) send_drain();
        settle_out();
    endtask

    // random mix of packets, commands, drains and unused words
    task automatic test_random_traffic(input int count, input int gap, input int stall);
        int pick;
        gap_pct   = gap;
        stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_word(OP_PACKET, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
            end else if (pick < 43) begin
                send_word(OP_COMMAND, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
            end else if (pick < 93) begin
                send_drain();
            end else begin
                send_word(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
            end
        end
        settle_out();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(180, 0, 0);
        test_random_traffic(180, 85, 0);
        test_random_traffic(180, 0, 85);
        test_random_traffic(180, 11, 11);
        test_ring_full();

        if (tx_expected_q.size() != 0) begin
            flag_mismatch($sformatf("%0d bytes never came out", tx_expected_q.size()));
        end
        $display("run covered %0d words: %0d bytes checked, %0d dropped on a full ring,",
                 words_seen, bytes_checked, bytes_dropped);
        $display("%0d drains on an empty ring, %0d mismatches", empty_drains, err_count);
        if (err_count == 0) begin
            $display("[usb_midi_packet_to_serial_fifo] OK");
        end else begin
            $display("[usb_midi_packet_to_serial_fifo] ERROR");
        end
        $finish;
    end

endmodule
